FILE: src/lgcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LCD glyph command sequencer package
// Shared constants, operation codes and the command queue entry type.
// ----------------------------------------------------------------------------
package lgcs_pkg;

	localparam int GLYPH_BYTES = 16;
	localparam int WORDS_PER_CHAR = 64;

	// Operation codes carried on the op field.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	// Character code of the first glyph in the font.
	localparam logic [7:0] CODE_BASE = 8'd32;

	// Display protocol constants.
	localparam logic [7:0] CMD_PAGE   = 8'hB0;
	localparam logic [7:0] CMD_COL_HI = 8'h10;
	localparam logic [7:0] COL_ORIGIN = 8'd129;

	// One classified command waiting for the sequencer. The address is already
	// wrapped into the font store and the glyph index is already reduced.
	typedef struct packed {
		logic        op;
		logic [10:0] font_address;
		logic [7:0]  font_byte;
		logic [7:0]  glyph;
		logic [1:0]  text_row;
		logic [4:0]  text_column;
		logic        invert;
	} cmd_entry_t;

endpackage
`default_nettype wire

FILE: src/lgcs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lgcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: src/lgcs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LCD glyph command sequencer front end
// Accepts commands, reduces the glyph index and load address, and holds them
// in a two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
module lgcs_front
	import lgcs_pkg::*;
#(
	parameter int FONT_GLYPHS = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        op,
	input  wire logic [10:0] font_address,
	input  wire logic [7:0]  font_byte,
	input  wire logic [1:0]  text_row,
	input  wire logic [4:0]  text_column,
	input  wire logic [7:0]  char_code,
	input  wire logic        invert,
	output logic             busy,
	output cmd_entry_t       head,
	output logic             head_valid,
	input  wire logic        pop
);

	localparam int FONT_DEPTH = FONT_GLYPHS * GLYPH_BYTES;

	cmd_entry_t  entry;
	cmd_entry_t  queue_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	logic [9:0]  glyph_acc;
	logic [11:0] addr_ext;

	// Biasing by the glyph count keeps the value positive for codes below the
	// base; it then stays under four times the glyph count.
	always_comb begin
		glyph_acc = {2'b00, char_code} + 10'(FONT_GLYPHS) - {2'b00, CODE_BASE};
		for (int k = 0; k < 3; k++) begin
			if (glyph_acc >= 10'(FONT_GLYPHS)) begin
				glyph_acc = glyph_acc - 10'(FONT_GLYPHS);
			end
		end
	end

	// The address field is below twice the smallest store depth.
	always_comb begin
		addr_ext = {1'b0, font_address};
		if (addr_ext >= 12'(FONT_DEPTH)) begin
			addr_ext = addr_ext - 12'(FONT_DEPTH);
		end
	end

	always_comb begin
		entry.op           = op;
		entry.font_address = addr_ext[10:0];
		entry.font_byte    = font_byte;
		entry.glyph        = glyph_acc[7:0];
		entry.text_row     = text_row;
		entry.text_column  = text_column;
		entry.invert       = invert;
	end

	assign busy       = (count_q == 2'd2);
	assign push       = start && !busy;
	assign head       = queue_q[rd_ptr_q];
	assign head_valid = (count_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: src/lgcs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LCD glyph command sequencer back end
// Executes queued commands: writes font bytes, and walks the 64-word display
// sequence of a character through a registered output stage.
// ----------------------------------------------------------------------------
module lgcs_back
	import lgcs_pkg::*;
#(
	parameter int FONT_GLYPHS = 128
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire cmd_entry_t                             head,
	input  wire logic                                   head_valid,
	output logic                                        pop,
	output logic                                        active,
	output logic                                        ram_we,
	output logic [$clog2(FONT_GLYPHS*GLYPH_BYTES)-1:0]  ram_waddr,
	output logic [7:0]                                  ram_wdata,
	output logic [$clog2(FONT_GLYPHS*GLYPH_BYTES)-1:0]  ram_raddr,
	input  wire logic [7:0]                             ram_rdata,
	output logic                                        strobe,
	output logic [8:0]                                  spi_word,
	output logic                                        last
);

	localparam int AW = $clog2(FONT_GLYPHS * GLYPH_BYTES);

	// Word position within one display column.
	localparam logic [1:0] PH_PAGE   = 2'd0;
	localparam logic [1:0] PH_COL_HI = 2'd1;
	localparam logic [1:0] PH_COL_LO = 2'd2;
	localparam logic [1:0] PH_DATA   = 2'd3;

	logic        active_q;
	logic [5:0]  cnt_q;
	logic [7:0]  glyph_q;
	logic [1:0]  row_q;
	logic [4:0]  col_q;
	logic        inv_q;
	logic        strobe_q;
	logic [8:0]  word_q;
	logic        last_q;
	logic [8:0]  word_next;
	logic [7:0]  col_addr;
	logic [2:0]  page;
	logic [11:0] raddr_full;
	logic [11:0] waddr_full;

	assign pop       = head_valid && !active_q;
	assign active    = active_q;
	assign ram_we    = pop && (head.op == OP_LOAD);
	assign waddr_full = {1'b0, head.font_address};
	assign ram_waddr = waddr_full[AW-1:0];
	assign ram_wdata = head.font_byte;

	// The address holds for a whole column, so the registered read is ready
	// by the data word.
	assign raddr_full = {glyph_q, cnt_q[5:2]};
	assign ram_raddr  = raddr_full[AW-1:0];

	assign page     = {row_q, cnt_q[5]};
	assign col_addr = COL_ORIGIN - {col_q, 3'b000} - {5'd0, cnt_q[4:2]};

	always_comb begin
		unique case (cnt_q[1:0])
			PH_PAGE:   word_next = {1'b0, CMD_PAGE | {5'd0, page}};
			PH_COL_HI: word_next = {1'b0, CMD_COL_HI | {4'd0, col_addr[7:4]}};
			PH_COL_LO: word_next = {5'd0, col_addr[3:0]};
			PH_DATA:   word_next = {1'b1, ram_rdata ^ {8{inv_q}}};
			default:   word_next = 9'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop && (head.op == OP_DRAW)) begin
			glyph_q <= head.glyph;
			row_q   <= head.text_row;
			col_q   <= head.text_column;
			inv_q   <= head.invert;
		end
		if (active_q) begin
			word_q <= word_next;
			last_q <= (cnt_q == 6'(WORDS_PER_CHAR - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= 6'd0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (active_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(WORDS_PER_CHAR - 1)) begin
					active_q <= 1'b0;
				end
			end else if (pop && (head.op == OP_DRAW)) begin
				active_q <= 1'b1;
				cnt_q    <= 6'd0;
			end
		end
	end

	assign strobe   = strobe_q;
	assign spi_word = word_q;
	assign last     = strobe_q && last_q;

endmodule
`default_nettype wire

FILE: src/lcd_glyph_command_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// A draw produces 64 words on consecutive cycles; the command passes from the queue
// into the registered sequencer state, and each word through the output register.
// A load writes its font byte as the sequencer takes it from the queue.
// A two-entry queue decouples the command port from the sequencer; busy is high
// while it is full. Reset clears the queue and sequencer control; the font
// memory is not cleared and its contents are undefined until loaded.
// ----------------------------------------------------------------------------
// LCD glyph command sequencer
// Loads an 8x16 font and turns draw commands into page-addressed display words.
// ----------------------------------------------------------------------------
module lcd_glyph_command_sequencer
	import lgcs_pkg::*;
#(
	parameter int FONT_GLYPHS = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        op,
	input  wire logic [10:0] font_address,
	input  wire logic [7:0]  font_byte,
	input  wire logic [1:0]  text_row,
	input  wire logic [4:0]  text_column,
	input  wire logic [7:0]  char_code,
	input  wire logic        invert,
	output logic             strobe,
	output logic [8:0]       spi_word,
	output logic             last
);

	localparam int FONT_DEPTH = FONT_GLYPHS * GLYPH_BYTES;
	localparam int AW = $clog2(FONT_DEPTH);

	cmd_entry_t    head;
	logic          head_valid;
	logic          pop;
	logic          active;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	lgcs_front #(
		.FONT_GLYPHS(FONT_GLYPHS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.op          (op),
		.font_address(font_address),
		.font_byte   (font_byte),
		.text_row    (text_row),
		.text_column (text_column),
		.char_code   (char_code),
		.invert      (invert),
		.busy        (busy),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop)
	);

	lgcs_back #(
		.FONT_GLYPHS(FONT_GLYPHS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(head_valid),
		.pop       (pop),
		.active    (active),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.strobe    (strobe),
		.spi_word  (spi_word),
		.last      (last)
	);

	lgcs_ram #(
		.WIDTH(8),
		.DEPTH(FONT_DEPTH)
	) u_font_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

`ifndef ASSERT_OFF
	// The final word closes a character and is never followed directly by another.
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |=> !strobe)
		else $error("word emitted directly after the final word of a character");

	// Font writes never overlap an active character sequence.
	a_no_load_in_draw: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !active)
		else $error("font write while a character is being sent");

	// Words appear only in the cycle after the sequencer was active.
	a_strobe_source: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(active))
		else $error("output word without an active sequence");

	// The sequencer only takes work that the queue holds.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid && !active)
		else $error("queue read while empty or while sequencing");
`endif

endmodule
`default_nettype wire
